/* sv/fixed_block_pool_allocator_defines.svh */
// assertion macros shared by the block pool allocator rtl
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define FBPA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fbpa assertion failed");
// next-cycle implication
`define FBPA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fbpa assertion failed");
`else
`define FBPA_ASSERT_NOW(label, clk, rstn, ante, cons)
`define FBPA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

/* sv/fbpa_pkg.sv */
// types and constants of the block pool allocator
package fbpa_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;

    // fixed field widths
    localparam int ACT_FW  = 1;
    localparam int IDX_FW  = 8;
    localparam int CNT_FW  = 9;
    localparam int BS_FW   = 16;
    localparam int OFS_FW  = 24;
    localparam int CFG_AW  = 1;
    localparam int CFG_DW  = 16;
    localparam int CMP_W   = (CNT_W > CNT_FW) ? CNT_W : CNT_FW;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_NUM_BLOCKS = 1'b0;
    localparam logic [CFG_AW-1:0] REG_BLOCK_SIZE = 1'b1;

    // actions
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [CNT_FW-1:0] NUM_BLOCKS_RST = CNT_FW'(256);
    localparam logic [BS_FW-1:0]  BLOCK_SIZE_RST = BS_FW'(64);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic start;
        logic commit;
    } ctl_t;

    typedef struct packed {
        logic              ok;
        logic [IDX_FW-1:0] given_index;
        logic [OFS_FW-1:0] byte_offset;
        logic [CNT_FW-1:0] used_count;
        logic [CNT_FW-1:0] free_count;
        logic [CNT_FW-1:0] watermark;
    } res_t;

endpackage

/* sv/fbpa_ram.sv */
// generic single-clock ram, one write port, one registered read port
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/fbpa_core.sv */
// pool state, link memory and the allocate / free update
`include "fixed_block_pool_allocator_defines.svh"

module fbpa_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fbpa_pkg::ctl_t                ctl,
    input  logic                          action,
    input  logic [fbpa_pkg::IDX_FW-1:0]   block_index,
    input  logic [fbpa_pkg::CNT_FW-1:0]   num_blocks,
    input  logic [fbpa_pkg::BS_FW-1:0]    block_size,
    output fbpa_pkg::res_t                res
);

    localparam int IDX_W = fbpa_pkg::IDX_W;
    localparam int CNT_W = fbpa_pkg::CNT_W;
    localparam int CMP_W = fbpa_pkg::CMP_W;

    logic                      action_reg;
    logic [fbpa_pkg::IDX_FW-1:0] index_reg;
    logic [IDX_W-1:0]          head_reg, head_next;
    logic [IDX_W-1:0]          tail_reg, tail_next;
    logic [CNT_W-1:0]          used_reg, used_next;
    logic [CNT_W-1:0]          high_reg, high_next;

    logic [IDX_W-1:0]          link_rd;
    logic                      link_we;
    logic [CNT_W-1:0]          n_eff;
    logic                      list_nonempty;
    logic                      alloc_ok;
    logic                      free_ok;
    logic [IDX_W-1:0]          given;
    logic [fbpa_pkg::IDX_FW-1:0] given8;

    // link memory, read address is always the list head
    fbpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (fbpa_pkg::MAX_BLOCKS)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (link_we),
        .wr_addr (tail_reg),
        .wr_data (IDX_W'(index_reg)),
        .rd_addr (head_reg),
        .rd_data (link_rd)
    );

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            action_reg <= action;
            index_reg  <= block_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            used_reg <= '0;
            high_reg <= '0;
        end else if (ctl.commit) begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            used_reg <= used_next;
            high_reg <= high_next;
        end
    end

    always_comb begin
        // clamp block count to the pool size
        if (CMP_W'(num_blocks) > CMP_W'(fbpa_pkg::MAX_BLOCKS)) begin
            n_eff = CNT_W'(fbpa_pkg::MAX_BLOCKS);
        end else begin
            n_eff = CNT_W'(num_blocks);
        end

        list_nonempty = high_reg > used_reg;
        alloc_ok = (action_reg == fbpa_pkg::ACT_ALLOC) && (used_reg < n_eff);
        free_ok  = (action_reg == fbpa_pkg::ACT_FREE) && (used_reg != '0)
                   && (CMP_W'(index_reg) < CMP_W'(n_eff));

        given = list_nonempty ? head_reg : IDX_W'(high_reg);

        head_next = head_reg;
        tail_next = tail_reg;
        used_next = used_reg;
        high_next = high_reg;
        link_we   = 1'b0;

        if (alloc_ok) begin
            used_next = used_reg + CNT_W'(1);
            if (list_nonempty) begin
                head_next = link_rd;
            end else begin
                high_next = used_reg + CNT_W'(1);
            end
        end else if (free_ok) begin
            used_next = used_reg - CNT_W'(1);
            tail_next = IDX_W'(index_reg);
            if (list_nonempty) begin
                link_we = ctl.commit;
            end else begin
                head_next = IDX_W'(index_reg);
            end
        end

        given8 = alloc_ok ? fbpa_pkg::IDX_FW'(given) : '0;

        res.ok          = alloc_ok || free_ok;
        res.given_index = given8;
        res.byte_offset = fbpa_pkg::OFS_FW'(given8) * fbpa_pkg::OFS_FW'(block_size);
        res.used_count  = fbpa_pkg::CNT_FW'(used_next);
        res.free_count  = (n_eff > used_next) ? fbpa_pkg::CNT_FW'(n_eff - used_next) : '0;
        res.watermark   = fbpa_pkg::CNT_FW'(high_next);
    end

    `FBPA_ASSERT_NOW(a_used_le_mark, aclk, aresetn, 1'b1, used_reg <= high_reg)
    `FBPA_ASSERT_NOW(a_mark_le_max, aclk, aresetn, 1'b1,
                     CMP_W'(high_reg) <= CMP_W'(fbpa_pkg::MAX_BLOCKS))
    `FBPA_ASSERT_NEXT(a_alloc_counts, aclk, aresetn, ctl.commit && alloc_ok,
                      used_reg == $past(used_reg) + CNT_W'(1))

endmodule

/* sv/fixed_block_pool_allocator.sv */
// top level of the fixed-size block pool allocator
//
// channel | ports                          | direction | carries
// --------+--------------------------------+-----------+----------------------------------
// request | s_valid s_ready s_*            | in        | action, block_index
// result  | m_valid m_ready m_*            | out       | ok, index, offset, counts, mark
// config  | cfg_we cfg_index cfg_data      | in        | num_blocks, block_size
//
// an item is accepted in the idle state, where the link memory is read at the list head,
// then the exec state updates the pool state and loads the result register
// one item is in flight at a time; the next is only taken after the current one commits
// the next item is taken while a finished result still waits in the output register
// if the output register is still full, the update waits in the exec state
// reset (synchronous, active low) empties the pool and restores the default registers
`include "fixed_block_pool_allocator_defines.svh"

module fixed_block_pool_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_we,
    input  logic [fbpa_pkg::CFG_AW-1:0]   cfg_index,
    input  logic [fbpa_pkg::CFG_DW-1:0]   cfg_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fbpa_pkg::ACT_FW-1:0]   s_action,
    input  logic [fbpa_pkg::IDX_FW-1:0]   s_block_index,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_ok,
    output logic [fbpa_pkg::IDX_FW-1:0]   m_given_index,
    output logic [fbpa_pkg::OFS_FW-1:0]   m_byte_offset,
    output logic [fbpa_pkg::CNT_FW-1:0]   m_used_count,
    output logic [fbpa_pkg::CNT_FW-1:0]   m_free_count,
    output logic [fbpa_pkg::CNT_FW-1:0]   m_watermark
);

    fbpa_pkg::state_t state_reg, state_next;
    fbpa_pkg::ctl_t   ctl;
    fbpa_pkg::res_t   res;
    fbpa_pkg::res_t   out_reg;
    logic             m_valid_reg, m_valid_next;

    logic [fbpa_pkg::CNT_FW-1:0] num_blocks_reg;
    logic [fbpa_pkg::BS_FW-1:0]  block_size_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_blocks_reg <= fbpa_pkg::NUM_BLOCKS_RST;
            block_size_reg <= fbpa_pkg::BLOCK_SIZE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                fbpa_pkg::REG_NUM_BLOCKS: num_blocks_reg <= fbpa_pkg::CNT_FW'(cfg_data);
                fbpa_pkg::REG_BLOCK_SIZE: block_size_reg <= fbpa_pkg::BS_FW'(cfg_data);
                default: ;
            endcase
        end
    end

    // pool state and link memory
    fbpa_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .action      (s_action[0]),
        .block_index (s_block_index),
        .num_blocks  (num_blocks_reg),
        .block_size  (block_size_reg),
        .res         (res)
    );

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fbpa_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, loaded on commit
    always_ff @(posedge aclk) begin
        if (ctl.commit) begin
            out_reg <= res;
        end
    end

    always_comb begin
        state_next   = state_reg;
        ctl.start    = 1'b0;
        ctl.commit   = 1'b0;
        s_ready      = 1'b0;
        // drop the result once taken
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            fbpa_pkg::ST_IDLE: begin
                // head link read is launched on the accept edge
                s_ready   = 1'b1;
                ctl.start = s_valid;
                if (s_valid) begin
                    state_next = fbpa_pkg::ST_EXEC;
                end
            end
            fbpa_pkg::ST_EXEC: begin
                // commit once the output register is free or being emptied
                if (!m_valid_reg || m_ready) begin
                    ctl.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = fbpa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fbpa_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_ok          = out_reg.ok;
    assign m_given_index = out_reg.given_index;
    assign m_byte_offset = out_reg.byte_offset;
    assign m_used_count  = out_reg.used_count;
    assign m_free_count  = out_reg.free_count;
    assign m_watermark   = out_reg.watermark;

    `FBPA_ASSERT_NEXT(a_accept_to_exec, aclk, aresetn, s_valid && s_ready,
                      state_reg == fbpa_pkg::ST_EXEC)
    `FBPA_ASSERT_NEXT(a_exec_waits, aclk, aresetn,
                      state_reg == fbpa_pkg::ST_EXEC && m_valid_reg && !m_ready,
                      state_reg == fbpa_pkg::ST_EXEC && m_valid_reg)
    `FBPA_ASSERT_NOW(a_fail_zero, aclk, aresetn, m_valid_reg && !out_reg.ok,
                     out_reg.given_index == '0 && out_reg.byte_offset == '0)

endmodule
